FILE: sv/glp_pkg.sv
// Shared types and constants for the greedy label placer.
// No dependencies; imported by every module of the block.
`default_nettype none
package glp_pkg;
	localparam int MAX_LABELS_DEF = 64;
	localparam int CW = 18;   // wide enough for any candidate edge before the viewport test

	localparam logic [1:0] OP_AT    = 2'd0;
	localparam logic [1:0] OP_NEAR  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_PLACED  = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_CLEARED = 2'd3;

	localparam logic [1:0] REG_MIN_X = 2'd0;
	localparam logic [1:0] REG_MIN_Y = 2'd1;
	localparam logic [1:0] REG_MAX_X = 2'd2;
	localparam logic [1:0] REG_MAX_Y = 2'd3;

	typedef logic signed [CW-1:0] crd_t;

	typedef struct packed {
		crd_t x0;
		crd_t y0;
		crd_t x1;
		crd_t y1;
	} box_t;

	typedef struct packed {
		logic signed [15:0] min_x;
		logic signed [15:0] min_y;
		logic signed [15:0] max_x;
		logic signed [15:0] max_y;
	} view_t;

	// one classified request, as handed from front to back
	typedef struct packed {
		logic [1:0]        op;
		logic [3:0][1:0]   order;   // candidate try order
		logic [3:0]        vp_ok;   // candidate lies inside viewport
		box_t [3:0]        box;
		logic [3:0][15:0]  px;
		logic [3:0][15:0]  py;
	} cmd_t;
endpackage
`default_nettype wire

FILE: sv/glp_front.sv
// Front end: builds the candidate boxes of a request and checks them against the viewport.
// Depends on glp_pkg.
`default_nettype none
module glp_front (
	input  wire logic [1:0]          operation,
	input  wire logic signed [15:0]  anchor_x,
	input  wire logic signed [15:0]  anchor_y,
	input  wire logic [14:0]         offset_x,
	input  wire logic [14:0]         offset_y,
	input  wire logic [14:0]         text_width,
	input  wire logic [14:0]         text_height,
	input  wire logic [14:0]         padding,
	input  wire logic [1:0]          first_quadrant,
	input  wire glp_pkg::view_t      view,
	output glp_pkg::cmd_t            cmd
);
	import glp_pkg::*;

	crd_t ax, ay, ox, oy, w, h, pad;
	crd_t cx [4];
	crd_t cy [4];
	crd_t vminx, vminy, vmaxx, vmaxy;

	always_comb begin
		ax  = CW'(anchor_x);
		ay  = CW'(anchor_y);
		ox  = crd_t'({3'b0, offset_x});
		oy  = crd_t'({3'b0, offset_y});
		w   = crd_t'({3'b0, text_width});
		h   = crd_t'({3'b0, text_height});
		pad = crd_t'({3'b0, padding});
		vminx = CW'(view.min_x);
		vminy = CW'(view.min_y);
		vmaxx = CW'(view.max_x);
		vmaxy = CW'(view.max_y);

		cx[0] = ax + ox;      cy[0] = ay - oy - h;
		cx[1] = ax + ox;      cy[1] = ay + oy;
		cx[2] = ax - ox - w;  cy[2] = ay - oy - h;
		cx[3] = ax - ox - w;  cy[3] = ay + oy;

		cmd = '0;
		cmd.op = operation;
		if (operation == OP_AT) begin
			cx[0] = ax;
			cy[0] = ay;
		end
		for (int k = 0; k < 4; k++) begin
			cmd.px[k]     = cx[k][15:0];
			cmd.py[k]     = cy[k][15:0];
			cmd.box[k].x0 = cx[k] - pad;
			cmd.box[k].y0 = cy[k] - pad;
			cmd.box[k].x1 = cx[k] + w + pad;
			cmd.box[k].y1 = cy[k] + h + pad;
			cmd.vp_ok[k]  = (cmd.box[k].x0 >= vminx) && (cmd.box[k].y0 >= vminy) &&
				(cmd.box[k].x1 <= vmaxx) && (cmd.box[k].y1 <= vmaxy);
		end
		if (operation == OP_NEAR) begin
			// preferred first, then the other three ascending
			cmd.order[0] = first_quadrant;
			for (int j = 1; j < 4; j++) begin
				cmd.order[j] = (2'(j - 1) >= first_quadrant) ? 2'(j) : 2'(j - 1);
			end
		end else begin
			cmd.order = '0;
			cmd.vp_ok[3:1] = 3'b000;
		end
	end
endmodule
`default_nettype wire

FILE: sv/glp_queue.sv
// Two-entry word queue between front and back.
// Depends on glp_pkg.
`default_nettype none
module glp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire glp_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output glp_pkg::cmd_t      pop_data
);
	import glp_pkg::*;

	cmd_t        slot_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

FILE: sv/glp_back.sv
// Back end: scans the box table, picks the first fitting candidate, stores it, and
// holds the result word. Depends on glp_pkg.
`default_nettype none
module glp_back #(
	parameter int MAX_LABELS = glp_pkg::MAX_LABELS_DEF,
	parameter int CNT_W = $clog2(MAX_LABELS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire glp_pkg::cmd_t cmd,
	output logic               cmd_pop,
	output logic               res_valid,
	input  wire logic          res_ready,
	output logic [1:0]         res_status,
	output logic [15:0]        res_x,
	output logic [15:0]        res_y,
	output logic [1:0]         res_quad,
	output logic [CNT_W-1:0]   res_count
);
	import glp_pkg::*;

	localparam int IDX_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [63:0]      mem [MAX_LABELS];
	logic [63:0]      rd_data_s1;
	logic             rd_v_s1;
	logic [1:0]       state_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] idx_q, cnt_q;
	logic [3:0]       hit_q, ov;
	logic             full_tbl, found, out_free;
	logic [1:0]       qsel;
	logic signed [CW-1:0] bx0, by0, bx1, by1;
	// next result word, taken when the done state can hand it over
	logic [1:0]       st_d, quad_d;
	logic [15:0]      x_d, y_d;
	logic [CNT_W-1:0] cnt_d;
	logic             place_d;

	assign full_tbl = (cnt_q == CNT_W'(MAX_LABELS));
	assign out_free = !res_valid || res_ready;
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;

	always_comb begin
		bx0 = CW'($signed(rd_data_s1[15:0]));
		by0 = CW'($signed(rd_data_s1[31:16]));
		bx1 = CW'($signed(rd_data_s1[47:32]));
		by1 = CW'($signed(rd_data_s1[63:48]));
		for (int k = 0; k < 4; k++) begin
			ov[k] = (cmd_q.box[k].x0 < bx1) && (cmd_q.box[k].x1 > bx0) &&
				(cmd_q.box[k].y0 < by1) && (cmd_q.box[k].y1 > by0);
		end
		found = 1'b0;
		qsel  = 2'd0;
		for (int k = 0; k < 4; k++) begin
			if (!found && cmd_q.vp_ok[cmd_q.order[k]] && !hit_q[cmd_q.order[k]]) begin
				found = 1'b1;
				qsel  = cmd_q.order[k];
			end
		end

		st_d    = ST_NOFIT;
		x_d     = '0;
		y_d     = '0;
		quad_d  = '0;
		cnt_d   = cnt_q;
		place_d = 1'b0;
		case (cmd_q.op) inside
			OP_CLEAR: begin
				cnt_d = '0;
				st_d  = ST_CLEARED;
			end
			OP_AT, OP_NEAR: begin
				if (full_tbl) begin
					st_d = ST_FULL;
				end else if (found) begin
					place_d = 1'b1;
					cnt_d   = cnt_q + 1'b1;
					st_d    = ST_PLACED;
					x_d     = cmd_q.px[qsel];
					y_d     = cmd_q.py[qsel];
					quad_d  = qsel;
				end
			end
			default: ;
		endcase
	end

	// table port: one read and one write a cycle
	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[idx_q[IDX_W-1:0]];
		if (state_q == S_DONE && out_free && place_d) begin
			mem[cnt_q[IDX_W-1:0]] <= {cmd_q.box[qsel].y1[15:0], cmd_q.box[qsel].x1[15:0],
				cmd_q.box[qsel].y0[15:0], cmd_q.box[qsel].x0[15:0]};
		end
		if (state_q == S_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			cnt_q      <= '0;
			hit_q      <= '0;
			rd_v_s1    <= 1'b0;
			res_valid  <= 1'b0;
			res_status <= ST_NOFIT;
			res_x      <= '0;
			res_y      <= '0;
			res_quad   <= '0;
			res_count  <= '0;
		end else begin
			if (state_q == S_DONE && out_free) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q   <= '0;
					hit_q   <= '0;
					rd_v_s1 <= 1'b0;
					if (cmd_valid) begin
						if ((cmd.op == OP_AT || cmd.op == OP_NEAR) && !full_tbl) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (rd_v_s1) hit_q <= hit_q | ov;
					if (idx_q < cnt_q) begin
						rd_v_s1 <= 1'b1;
						idx_q   <= idx_q + 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
						if (!rd_v_s1) state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_status <= st_d;
						res_x      <= x_d;
						res_y      <= y_d;
						res_quad   <= quad_d;
						res_count  <= cnt_d;
						cnt_q      <= cnt_d;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: sv/greedy_label_placer.sv
// Greedy label placer: top level with configuration registers, front end, queue and back end.
// Depends on glp_pkg, glp_front, glp_queue, glp_back.
`default_nettype none
// Each request gets exactly one result word. The front end classifies a request in the
// cycle it is accepted (candidate boxes, viewport test, try order) and drops it into a
// two-entry queue, so input is taken while the back end is busy. The back end reads the
// box table one entry per cycle through its single read port and tests all four
// candidates against each entry at once. A place request passes from idle through a scan
// of the entries below the count to the done state, while a clear, a full-table answer
// or the unused code 3 goes from idle straight to the done state.
// Results sit in an output register and may be held off by out_ready without losing
// anything. Configuration writes are always taken (cfg_ready is high) and must only
// come while the block is idle. Table entries need no clearing after reset: only
// entries below the count are ever read.
module greedy_label_placer #(
	parameter int MAX_LABELS = glp_pkg::MAX_LABELS_DEF,
	parameter int CNT_W = $clog2(MAX_LABELS + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         operation,
	input  wire logic signed [15:0] anchor_x,
	input  wire logic signed [15:0] anchor_y,
	input  wire logic [14:0]        offset_x,
	input  wire logic [14:0]        offset_y,
	input  wire logic [14:0]        text_width,
	input  wire logic [14:0]        text_height,
	input  wire logic [14:0]        padding,
	input  wire logic [1:0]         first_quadrant,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [15:0]      placed_x,
	output logic signed [15:0]      placed_y,
	output logic [1:0]              quadrant_used,
	output logic [CNT_W-1:0]        label_count
);
	import glp_pkg::*;

	view_t view_q;
	cmd_t  front_cmd, q_cmd;
	logic  q_full, q_valid, q_pop;
	logic [15:0] rx, ry;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;

	// viewport registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_q.min_x <= 16'sd0;
			view_q.min_y <= 16'sd0;
			view_q.max_x <= 16'sd32767;
			view_q.max_y <= 16'sd32767;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_X: view_q.min_x <= cfg_data;
				REG_MIN_Y: view_q.min_y <= cfg_data;
				REG_MAX_X: view_q.max_x <= cfg_data;
				REG_MAX_Y: view_q.max_y <= cfg_data;
				default: ;
			endcase
		end
	end

	glp_front u_front (
		.operation          (operation),
		.anchor_x           (anchor_x),
		.anchor_y           (anchor_y),
		.offset_x           (offset_x),
		.offset_y           (offset_y),
		.text_width         (text_width),
		.text_height        (text_height),
		.padding            (padding),
		.first_quadrant     (first_quadrant),
		.view               (view_q),
		.cmd                (front_cmd)
	);

	glp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_data (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_cmd)
	);

	glp_back #(
		.MAX_LABELS (MAX_LABELS),
		.CNT_W      (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd        (q_cmd),
		.cmd_pop    (q_pop),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res_status (status),
		.res_x      (rx),
		.res_y      (ry),
		.res_quad   (quadrant_used),
		.res_count  (label_count)
	);

	assign placed_x = rx;
	assign placed_y = ry;
endmodule
`default_nettype wire
